@@ design/hclp_pkg.sv @@
// Shared types, constants and codes of the hash cache.
package hclp_pkg;

  localparam int TABLE_SLOTS  = 64;
  localparam int SLOT_W       = $clog2(TABLE_SLOTS);
  localparam int PROBE_W      = SLOT_W + 1;
  localparam int ITEM_SLOTS   = 25;
  localparam int ITEM_W       = 5;
  localparam int EVICT_SEARCH = 16;
  localparam int SEARCH_W     = $clog2(EVICT_SEARCH + 1);
  localparam int GUARD_INIT   = (EVICT_SEARCH + 1) * TABLE_SLOTS;
  localparam int GUARD_W      = $clog2(GUARD_INIT + 1);
  localparam int LIMIT_MAX    = (ITEM_SLOTS < TABLE_SLOTS - 1) ? ITEM_SLOTS : TABLE_SLOTS - 1;
  localparam int AGE_W        = 3;

  localparam logic [31:0] CRC_SEED = 32'h9e37_7989;
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [63:0] GOLD64   = 64'h9e37_79b9_7f4a_7c15;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] CFG_ITEM_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_INITIAL_AGE = 2'd1;
  localparam logic [1:0] CFG_HASH_SELECT = 2'd2;
  localparam logic [1:0] CFG_MISS_VALUE  = 2'd3;

  localparam logic HASH_CRC  = 1'b0;
  localparam logic HASH_GOLD = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [63:0] value_in;
  } in_req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] res_value;
    logic        evicted;
    logic [4:0]  items_held;
  } out_res_t;

endpackage

@@ design/hclp_hash.sv @@
// Multi-cycle key hash: CRC32C a byte per cycle, or golden-ratio multiply on one shared multiplier.
module hclp_hash
  import hclp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        sel,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  output logic        done,
  output logic [31:0] hash
);

  localparam int PHASE_W = 5;

  logic               run_r, run_nxt;
  logic               mode_r, mode_nxt;
  logic               done_r, done_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [127:0]       data_r, data_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [31:0]        hash_r, hash_nxt;
  logic [31:0]        crc_step;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        acc_sum;
  logic [63:0]        fold1, fold2;

  function automatic logic [31:0] crc8(input logic [31:0] c_in, input logic [7:0] d);
    logic [31:0] c;
    logic        t;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      t = c[0] ^ d[i];
      c = c >> 1;
      if (t) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  assign crc_step = crc8(acc_r[31:0], data_r[7:0]);
  assign mul_a    = (phase_r == PHASE_W'(2)) ? data_r[63:32] : data_r[31:0];
  assign mul_b    = (phase_r == PHASE_W'(3)) ? GOLD64[63:32] : GOLD64[31:0];
  assign acc_sum  = acc_r + {prod_r[31:0], 32'd0};
  assign fold1    = acc_sum ^ (acc_sum >> 32);
  assign fold2    = fold1 ^ (fold1 >> 16);

  always_comb begin
    run_nxt   = run_r;
    mode_nxt  = mode_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    data_nxt  = data_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    hash_nxt  = hash_r;
    if (start) begin
      run_nxt  = 1'b1;
      mode_nxt = sel;
      if (sel == HASH_GOLD) begin
        data_nxt  = {64'd0, key_low ^ (key_high + GOLD64)};
        acc_nxt   = '0;
        phase_nxt = PHASE_W'(4);
      end else begin
        data_nxt  = {key_high, key_low};
        acc_nxt   = {32'd0, CRC_SEED};
        phase_nxt = PHASE_W'(16);
      end
    end else if (run_r) begin
      phase_nxt = phase_r - 1'b1;
      if (mode_r == HASH_CRC) begin
        acc_nxt  = {32'd0, crc_step};
        data_nxt = data_r >> 8;
        if (phase_r == PHASE_W'(1)) begin
          hash_nxt = crc_step;
          done_nxt = 1'b1;
          run_nxt  = 1'b0;
        end
      end else begin
        // low product first, then the two cross terms into the upper word
        prod_nxt = 64'(mul_a) * 64'(mul_b);
        if (phase_r == PHASE_W'(3)) acc_nxt = prod_r;
        else if (phase_r == PHASE_W'(2)) acc_nxt = acc_sum;
        if (phase_r == PHASE_W'(1)) begin
          hash_nxt = fold2[31:0];
          done_nxt = 1'b1;
          run_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    phase_r <= phase_nxt;
    data_r  <= data_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    hash_r  <= hash_nxt;
  end

  assign done = done_r;
  assign hash = hash_r;

endmodule

@@ design/hash_cache_linear_probe_aging.sv @@
// Top level of the hash cache: sequencer, slot table, item store and config registers.
// Usage:
//   Raise start with in_req while busy is low; the request is taken at that edge and
//   busy stays high until the result is produced. One result per request appears on
//   out_res for exactly one cycle with out_valid high; the receiver cannot stall it.
//   Config writes (cfg_valid, cfg_index, cfg_data) are always ready; write them while
//   the block is idle. Register order: item_limit, initial_age, hash_select, miss_value.
// Sequence:
//   The hash is CRC32C, one byte per cycle, or a multiply hash on one 32x32 multiplier
//   used three times. Each probed slot then takes a read and a check state on the slot
//   table (one read and one write port), plus a key state for the item store read when
//   the stored hash matches. A put at the item limit first scans for a victim (read, check
//   per slot; up to 16 used slots, or 17 sweeps of an empty table at most), then rereads it.
//   Clear and the unused op code never raise busy: the result follows one cycle after
//   the request, and a new request can be taken at the next edge.
// Reset:
//   All slots empty, item count and eviction pointer zero, registers at their defaults.
//   No clearing pass: per-slot valid bits mark what was written since reset or clear.
module hash_cache_linear_probe_aging
  import hclp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_HASH    = 9'b000000010,
    S_EV_RD   = 9'b000000100,
    S_EV_CHK  = 9'b000001000,
    S_VIC_RD  = 9'b000010000,
    S_VIC_CHK = 9'b000100000,
    S_PR_RD   = 9'b001000000,
    S_PR_CHK  = 9'b010000000,
    S_PR_KEY  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [AGE_W-1:0]  age;
    logic [31:0]       hash;
    logic [ITEM_W-1:0] item;
  } tbl_row_t;

  typedef struct packed {
    logic [63:0] klo;
    logic [63:0] khi;
    logic [63:0] val;
  } kv_row_t;

  state_t              state_r, state_nxt;
  in_req_t             req_r, req_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [PROBE_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [GUARD_W-1:0]  guard_r, guard_nxt;
  logic [SEARCH_W-1:0] search_r, search_nxt;
  logic [3:0]          best_r, best_nxt;
  logic [SLOT_W-1:0]   vic_r, vic_nxt;
  tbl_row_t            vic_row_r, vic_row_nxt;
  logic                vic_hit_r, vic_hit_nxt;
  logic [ITEM_W-1:0]   new_item_r, new_item_nxt;
  logic [ITEM_W-1:0]   total_r, total_nxt;
  logic [SLOT_W-1:0]   eptr_r, eptr_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_res_t            out_r, out_nxt;

  logic [4:0]          lim_r;
  logic [2:0]          iage_r;
  logic                hsel_r;
  logic [63:0]         miss_r;

  tbl_row_t            tbl_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] tbl_vld_r;
  tbl_row_t            tbl_rd_r;
  logic                tbl_rdv_r;
  logic                tbl_we;
  logic [SLOT_W-1:0]   tbl_wa, tbl_ra;
  tbl_row_t            tbl_wd;
  logic                tbl_clr;

  kv_row_t             kv_mem [ITEM_SLOTS];
  kv_row_t             kv_rd_r;
  logic                kv_we;
  logic [ITEM_W-1:0]   kv_wa, kv_ra;
  kv_row_t             kv_wd;

  logic                hash_start, hash_done;
  logic [31:0]         hash_val;

  logic [AGE_W-1:0]    age_rd;
  logic [ITEM_W-1:0]   lim_eff;
  logic [AGE_W-1:0]    ia_eff;
  logic [SEARCH_W-1:0] ev_srch;
  logic [PROBE_W-1:0]  pr_cnt;
  logic                fin_miss, fin_hit, free_ok, pr_adv;

  hclp_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (hash_start),
    .sel      (hsel_r),
    .key_low  (req_nxt.key_low),
    .key_high (req_nxt.key_high),
    .done     (hash_done),
    .hash     (hash_val)
  );

  assign age_rd  = tbl_rdv_r ? tbl_rd_r.age : '0;
  assign lim_eff = (lim_r == 5'd0) ? ITEM_W'(1) :
                   (lim_r > 5'(LIMIT_MAX)) ? ITEM_W'(LIMIT_MAX) : lim_r;
  assign ia_eff  = (iage_r < 3'd2) ? 3'd2 : iage_r;
  assign pr_cnt  = cnt_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    guard_nxt     = guard_r;
    search_nxt    = search_r;
    best_nxt      = best_r;
    vic_nxt       = vic_r;
    vic_row_nxt   = vic_row_r;
    vic_hit_nxt   = vic_hit_r;
    new_item_nxt  = new_item_r;
    total_nxt     = total_r;
    eptr_nxt      = eptr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    tbl_we        = 1'b0;
    tbl_wa        = slot_r;
    tbl_wd        = tbl_rd_r;
    tbl_ra        = slot_r;
    tbl_clr       = 1'b0;
    kv_we         = 1'b0;
    kv_wa         = tbl_rd_r.item;
    kv_wd         = kv_rd_r;
    kv_ra         = tbl_rd_r.item;
    hash_start    = 1'b0;
    ev_srch       = search_r;
    fin_miss      = 1'b0;
    fin_hit       = 1'b0;
    free_ok       = 1'b0;
    pr_adv        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt      = in_req;
          vic_hit_nxt  = 1'b0;
          new_item_nxt = total_r;
          if (in_req.op == OP_LOOKUP || in_req.op == OP_PUT) begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end else begin
            if (in_req.op == OP_CLEAR) begin
              tbl_clr   = 1'b1;
              total_nxt = '0;
            end
            out_valid_nxt      = 1'b1;
            out_nxt.found      = 1'b0;
            out_nxt.res_value  = miss_r;
            out_nxt.evicted    = 1'b0;
            out_nxt.items_held = total_nxt;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          if (req_r.op == OP_PUT && total_r >= lim_eff) begin
            idx_nxt    = eptr_r;
            vic_nxt    = eptr_r;
            guard_nxt  = GUARD_W'(GUARD_INIT);
            search_nxt = SEARCH_W'(EVICT_SEARCH);
            best_nxt   = 4'd8;
            state_nxt  = S_EV_RD;
          end else begin
            slot_nxt  = hash_val[SLOT_W-1:0];
            cnt_nxt   = '0;
            state_nxt = S_PR_RD;
          end
        end
      end
      S_EV_RD: begin
        tbl_ra    = idx_r;
        state_nxt = S_EV_CHK;
      end
      S_EV_CHK: begin
        tbl_ra    = idx_r;
        guard_nxt = guard_r - 1'b1;
        if (age_rd >= 3'd2) begin
          if ({1'b0, age_rd} < best_r) begin
            vic_nxt  = idx_r;
            best_nxt = {1'b0, age_rd};
            if (age_rd == 3'd2) ev_srch = '0;
          end
          // age down every used slot passed without stopping
          if (ev_srch != '0) begin
            tbl_we     = 1'b1;
            tbl_wa     = idx_r;
            tbl_wd.age = age_rd - 1'b1;
            ev_srch    = ev_srch - 1'b1;
          end
        end
        search_nxt = ev_srch;
        idx_nxt    = idx_r + 1'b1;
        if (ev_srch != '0 && guard_nxt != '0) begin
          state_nxt = S_EV_RD;
        end else begin
          eptr_nxt  = idx_r + 1'b1;
          state_nxt = S_VIC_RD;
        end
      end
      S_VIC_RD: begin
        tbl_ra    = vic_r;
        state_nxt = S_VIC_CHK;
      end
      S_VIC_CHK: begin
        tbl_ra          = vic_r;
        vic_row_nxt     = tbl_rd_r;
        vic_row_nxt.age = age_rd;
        tbl_we          = 1'b1;
        tbl_wa          = vic_r;
        tbl_wd.age      = '0;
        if (total_r != '0) total_nxt = total_r - 1'b1;
        new_item_nxt    = tbl_rd_r.item;
        vic_hit_nxt     = 1'b1;
        slot_nxt        = hash_val[SLOT_W-1:0];
        cnt_nxt         = '0;
        state_nxt       = S_PR_RD;
      end
      S_PR_RD: begin
        state_nxt = S_PR_CHK;
      end
      S_PR_CHK: begin
        if (age_rd < 3'd2) begin
          fin_miss = 1'b1;
          free_ok  = 1'b1;
        end else if (tbl_rd_r.hash == hash_val && tbl_rd_r.item < ITEM_W'(ITEM_SLOTS)) begin
          state_nxt = S_PR_KEY;
        end else begin
          pr_adv = 1'b1;
        end
      end
      S_PR_KEY: begin
        if (kv_rd_r.klo == req_r.key_low && kv_rd_r.khi == req_r.key_high) begin
          fin_hit = 1'b1;
        end else begin
          pr_adv = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step to the next slot, give up after a full lap
    if (pr_adv) begin
      cnt_nxt  = pr_cnt;
      slot_nxt = slot_r + 1'b1;
      if (pr_cnt == PROBE_W'(TABLE_SLOTS)) fin_miss = 1'b1;
      else state_nxt = S_PR_RD;
    end

    if (fin_miss) begin
      state_nxt          = S_IDLE;
      out_valid_nxt      = 1'b1;
      out_nxt.found      = 1'b0;
      out_nxt.res_value  = miss_r;
      out_nxt.evicted    = 1'b0;
      if (req_r.op == OP_PUT && free_ok && new_item_r < ITEM_W'(ITEM_SLOTS)) begin
        tbl_we          = 1'b1;
        tbl_wa          = slot_r;
        tbl_wd.age      = ia_eff;
        tbl_wd.hash     = hash_val;
        tbl_wd.item     = new_item_r;
        kv_we           = 1'b1;
        kv_wa           = new_item_r;
        kv_wd.klo       = req_r.key_low;
        kv_wd.khi       = req_r.key_high;
        kv_wd.val       = req_r.value_in;
        total_nxt       = total_r + 1'b1;
        out_nxt.evicted = vic_hit_r;
      end
      out_nxt.items_held = total_nxt;
    end

    if (fin_hit) begin
      state_nxt         = S_IDLE;
      out_valid_nxt     = 1'b1;
      out_nxt.found     = 1'b1;
      out_nxt.evicted   = 1'b0;
      out_nxt.res_value = miss_r;
      if (req_r.op == OP_PUT) begin
        kv_we     = 1'b1;
        kv_wd.val = req_r.value_in;
        // a victim taken for nothing goes back with its aged state
        if (vic_hit_r) begin
          tbl_we    = 1'b1;
          tbl_wa    = vic_r;
          tbl_wd    = vic_row_r;
          total_nxt = total_r + 1'b1;
        end
      end else begin
        out_nxt.res_value = kv_rd_r.val;
        if (age_rd < 3'd7) begin
          tbl_we     = 1'b1;
          tbl_wa     = slot_r;
          tbl_wd.age = age_rd + 1'b1;
        end
      end
      out_nxt.items_held = total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_rd_r <= tbl_mem[tbl_ra];
    if (kv_we) kv_mem[kv_wa] <= kv_wd;
    if (kv_ra < ITEM_W'(ITEM_SLOTS)) kv_rd_r <= kv_mem[kv_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      tbl_rdv_r <= 1'b0;
    end else begin
      if (tbl_clr) tbl_vld_r <= '0;
      else if (tbl_we) tbl_vld_r[tbl_wa] <= 1'b1;
      tbl_rdv_r <= tbl_vld_r[tbl_ra] & ~tbl_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      eptr_r      <= '0;
      out_valid_r <= 1'b0;
      vic_hit_r   <= 1'b0;
      lim_r       <= 5'd25;
      iage_r      <= 3'd2;
      hsel_r      <= HASH_CRC;
      miss_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      eptr_r      <= eptr_nxt;
      out_valid_r <= out_valid_nxt;
      vic_hit_r   <= vic_hit_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ITEM_LIMIT:  lim_r  <= cfg_data[4:0];
          CFG_INITIAL_AGE: iage_r <= cfg_data[2:0];
          CFG_HASH_SELECT: hsel_r <= cfg_data[0];
          CFG_MISS_VALUE:  miss_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    slot_r     <= slot_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    guard_r    <= guard_nxt;
    search_r   <= search_nxt;
    best_r     <= best_nxt;
    vic_r      <= vic_nxt;
    vic_row_r  <= vic_row_nxt;
    new_item_r <= new_item_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

@@ dv/hash_cache_checker.sv @@
// Checker for the hash cache: tracks config writes, predicts each result and compares.
module hash_cache_checker
  import hclp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_req_t     in_req,
  input  logic        out_valid,
  input  out_res_t    out_res,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          hits,
  output int          evictions
);

  logic [2:0]  age_tbl   [TABLE_SLOTS];
  logic [31:0] hash_tbl  [TABLE_SLOTS];
  logic [4:0]  item_tbl  [TABLE_SLOTS];
  logic [63:0] key_lo_st [ITEM_SLOTS];
  logic [63:0] key_hi_st [ITEM_SLOTS];
  logic [63:0] value_st  [ITEM_SLOTS];
  int unsigned held;
  int unsigned sweep_ptr;

  logic [4:0]  lim_reg;
  logic [2:0]  age_reg;
  logic        hash_reg;
  logic [63:0] miss_reg;

  out_res_t expected_q[$];

  function automatic logic [31:0] crc_word(logic [31:0] c, logic [63:0] w);
    logic t;
    for (int i = 0; i < 64; i++) begin
      t = c[0] ^ w[i];
      c = c >> 1;
      if (t) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [31:0] calc_hash(logic [63:0] lo, logic [63:0] hi, logic sel);
    logic [63:0] h;
    if (sel == HASH_CRC) return crc_word(crc_word(CRC_SEED, lo), hi);
    h = lo ^ (hi + GOLD64);
    h = h * GOLD64;
    h = h ^ (h >> 32);
    h = h ^ (h >> 16);
    return h[31:0];
  endfunction

  task automatic find_key(input logic [31:0] h, input logic [63:0] lo, input logic [63:0] hi,
                          output bit hit, output int unsigned slot, output int unsigned free_slot);
    int unsigned s;
    s = h & (TABLE_SLOTS - 1);
    hit = 0;
    slot = 0;
    for (int n = 0; n < TABLE_SLOTS && age_tbl[s] >= 2; n++) begin
      if (hash_tbl[s] == h && item_tbl[s] < ITEM_SLOTS && key_lo_st[item_tbl[s]] == lo &&
          key_hi_st[item_tbl[s]] == hi) begin
        hit = 1;
        slot = s;
        break;
      end
      s = (s + 1) % TABLE_SLOTS;
    end
    free_slot = s;
  endtask

  // Scan for the youngest used slot from the rotating pointer, aging the ones passed.
  task automatic pick_victim(output int unsigned victim);
    int unsigned best, idx, search, guard;
    logic [2:0] a;
    best = 8;
    idx = sweep_ptr;
    victim = idx;
    search = EVICT_SEARCH;
    guard = GUARD_INIT;
    while (search > 0 && guard > 0) begin
      a = age_tbl[idx];
      guard--;
      if (a >= 2) begin
        if (a < best) begin
          victim = idx;
          best = a;
          if (a == 2) search = 0;
        end
        if (search > 0) begin
          age_tbl[idx] = a - 3'd1;
          search--;
        end
      end
      idx = (idx + 1) % TABLE_SLOTS;
    end
    sweep_ptr = idx;
  endtask

  task automatic wipe_table();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      age_tbl[i] = 0;
      hash_tbl[i] = 0;
      item_tbl[i] = 0;
    end
    for (int i = 0; i < ITEM_SLOTS; i++) begin
      key_lo_st[i] = 0;
      key_hi_st[i] = 0;
      value_st[i] = 0;
    end
    held = 0;
  endtask

  task automatic predict_cache(input in_req_t r, output out_res_t e);
    bit hit, had_victim;
    int unsigned slot, free_slot, victim, new_item, lim;
    logic [2:0] victim_age;
    logic [31:0] h;
    e = '0;
    e.res_value = miss_reg;
    case (r.op)
      OP_LOOKUP: begin
        h = calc_hash(r.key_low, r.key_high, hash_reg);
        find_key(h, r.key_low, r.key_high, hit, slot, free_slot);
        if (hit) begin
          e.found = 1;
          e.res_value = value_st[item_tbl[slot]];
          if (age_tbl[slot] < 7) age_tbl[slot] = age_tbl[slot] + 3'd1;
        end
      end
      OP_PUT: begin
        had_victim = 0;
        victim = 0;
        victim_age = 0;
        new_item = held;
        lim = (lim_reg == 0) ? 1 : (lim_reg > LIMIT_MAX) ? LIMIT_MAX : 32'(lim_reg);
        if (held >= lim) begin
          pick_victim(victim);
          had_victim = 1;
          victim_age = age_tbl[victim];
          age_tbl[victim] = 0;
          if (held > 0) held--;
          new_item = 32'(item_tbl[victim]);
        end
        h = calc_hash(r.key_low, r.key_high, hash_reg);
        find_key(h, r.key_low, r.key_high, hit, slot, free_slot);
        if (hit) begin
          // put back the victim when the key was already present
          if (had_victim) begin
            age_tbl[victim] = victim_age;
            held++;
          end
          e.found = 1;
          value_st[item_tbl[slot]] = r.value_in;
        end else if (new_item < ITEM_SLOTS && age_tbl[free_slot] < 2) begin
          hash_tbl[free_slot] = h;
          item_tbl[free_slot] = new_item[4:0];
          age_tbl[free_slot] = (age_reg < 2) ? 3'd2 : age_reg;
          key_lo_st[new_item] = r.key_low;
          key_hi_st[new_item] = r.key_high;
          value_st[new_item] = r.value_in;
          held++;
          e.evicted = had_victim;
        end
      end
      OP_CLEAR: wipe_table();
      default: ;
    endcase
    e.items_held = held[4:0];
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_res_t e;
    if (!rst_n) begin
      wipe_table();
      sweep_ptr = 0;
      lim_reg = 5'd25;
      age_reg = 3'd2;
      hash_reg = HASH_CRC;
      miss_reg = '0;
      expected_q.delete();
      fail_count = 0;
      checked = 0;
      hits = 0;
      evictions = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ITEM_LIMIT:  lim_reg = cfg_data[4:0];
          CFG_INITIAL_AGE: age_reg = cfg_data[2:0];
          CFG_HASH_SELECT: hash_reg = cfg_data[0];
          CFG_MISS_VALUE:  miss_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_res.res_value, '0);
        end else begin
          e = expected_q.pop_front();
          if (out_res.found !== e.found)
            report_mismatch("found", 64'(out_res.found), 64'(e.found));
          if (out_res.res_value !== e.res_value)
            report_mismatch("res_value", out_res.res_value, e.res_value);
          if (out_res.evicted !== e.evicted)
            report_mismatch("evicted", 64'(out_res.evicted), 64'(e.evicted));
          if (out_res.items_held !== e.items_held)
            report_mismatch("items_held", 64'(out_res.items_held), 64'(e.items_held));
          if (e.found) hits++;
          if (e.evicted) evictions++;
        end
        checked++;
      end
      if (start && !busy) begin
        predict_cache(in_req, e);
        expected_q.push_back(e);
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ dv/hash_cache_linear_probe_aging_tb.sv @@
// Testbench top for the hash cache: stimulus, config phases and verdict.
module hash_cache_linear_probe_aging_tb;
  import hclp_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int POOL = 48;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_req_t     in_req;
  logic        out_valid;
  out_res_t    out_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  int fail_count, pending, checked, hits, evictions;
  int sent;
  int cycles = 0;
  logic [63:0] pool_lo [POOL];
  logic [63:0] pool_hi [POOL];

  hash_cache_linear_probe_aging u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hash_cache_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .hits(hits), .evictions(evictions)
  );

  initial clk = 0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("hash_cache_linear_probe_aging regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Hold start until the request is taken; start stays high for a following request.
  task automatic send_req(input logic [1:0] op, input logic [63:0] lo, input logic [63:0] hi,
                          input logic [63:0] val);
    start <= 1'b1;
    in_req <= '{op: op, key_low: lo, key_high: hi, value_in: val};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle(0);
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL; i++) begin
      case ($urandom_range(0, 5))
        0: begin pool_lo[i] = '0; pool_hi[i] = rand64(); end
        1: begin pool_lo[i] = '1; pool_hi[i] = '1; end
        2: begin pool_lo[i] = rand64(); pool_hi[i] = 64'(i); end
        default: begin pool_lo[i] = rand64(); pool_hi[i] = rand64(); end
      endcase
    end
  endtask

  task automatic random_phase(input int count);
    int burst, k;
    int unsigned r;
    logic [1:0] op;
    int pool_used;
    pool_used = $urandom_range(4, POOL);
    while (count > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int b = 0; b < burst && count > 0; b++) begin
        r = $urandom_range(0, 99);
        op = (r < 45) ? OP_LOOKUP : (r < 93) ? OP_PUT : (r < 96) ? OP_CLEAR : OP_NONE;
        k = $urandom_range(0, pool_used - 1);
        if ($urandom_range(0, 9) == 0) send_req(op, rand64(), rand64(), rand64());
        else send_req(op, pool_lo[k], pool_hi[k], rand64());
        count--;
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
    end
  endtask

  initial begin
    logic [63:0] miss_pick;
    sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ITEM_LIMIT;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: miss on empty, insert, update, hit, age up to saturation, clear, unused op
    send_req(OP_LOOKUP, '0, '0, '0);
    send_req(OP_PUT, '0, '0, '1);
    send_req(OP_PUT, '1, '1, 64'h0123_4567_89ab_cdef);
    send_req(OP_PUT, '0, '0, 64'h5a5a_5a5a_a5a5_a5a5);
    for (int i = 0; i < 7; i++) send_req(OP_LOOKUP, '0, '0, '0);
    send_req(OP_LOOKUP, '1, '1, '0);
    send_req(OP_LOOKUP, '1, '0, '0);
    send_req(OP_NONE, '1, '1, '1);
    send_req(OP_CLEAR, '0, '0, '0);
    send_req(OP_LOOKUP, '1, '1, '0);
    drain();

    // tight limit with the multiply hash: every further insert evicts
    write_cfg(CFG_ITEM_LIMIT, 64'd1);
    write_cfg(CFG_INITIAL_AGE, 64'd7);
    write_cfg(CFG_HASH_SELECT, 64'(HASH_GOLD));
    write_cfg(CFG_MISS_VALUE, '1);
    send_req(OP_PUT, 64'd1, 64'd2, 64'd3);
    send_req(OP_PUT, 64'd4, 64'd5, 64'd6);
    send_req(OP_PUT, 64'd4, 64'd5, 64'd7);
    send_req(OP_LOOKUP, 64'd4, 64'd5, '0);
    send_req(OP_LOOKUP, 64'd1, 64'd2, '0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      refill_pool();
      case (phase)
        0: begin
          write_cfg(CFG_ITEM_LIMIT, 64'd0);
          write_cfg(CFG_INITIAL_AGE, 64'd0);
        end
        1: begin
          write_cfg(CFG_ITEM_LIMIT, 64'd31);
          write_cfg(CFG_INITIAL_AGE, 64'd2);
        end
        2: write_cfg(CFG_ITEM_LIMIT, 64'd25);
        default: begin
          write_cfg(CFG_ITEM_LIMIT, 64'($urandom_range(0, 31)));
          write_cfg(CFG_INITIAL_AGE, 64'($urandom_range(0, 7)));
        end
      endcase
      write_cfg(CFG_HASH_SELECT, 64'(phase[0]));
      miss_pick = (phase == 1) ? '0 : (phase == 2) ? '1 : rand64();
      write_cfg(CFG_MISS_VALUE, miss_pick);
      random_phase(190);
      drain();
      // shrink the limit under the current fill so inserts evict
      if (phase == 4) begin
        write_cfg(CFG_ITEM_LIMIT, 64'd3);
        random_phase(40);
        drain();
      end
    end

    drain();
    repeat (30) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d hits, %0d evictions",
             sent, checked, hits, evictions);
    if (fail_count == 0) begin
      $display("hash_cache_linear_probe_aging regression: pass");
    end else begin
      $display("hash_cache_linear_probe_aging regression: fail");
    end
    $finish;
  end

endmodule
